// File: hw/rtl/lebuf_pkg.sv
// Package for the line-edit input buffer.
// Holds the request and response structs, operation and result codes and the controller states.
// No dependencies.
package lebuf_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   // Spare code: ignored, no response.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] KIND_WRITE     = 2'd0;
   localparam logic [1:0] KIND_READ_BYTE = 2'd1;
   localparam logic [1:0] KIND_EMPTY     = 2'd2;
   localparam logic [1:0] KIND_CLEAR     = 2'd3;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NUL       = 8'd0;

   // Most bytes a single read may return.
   localparam logic [6:0] MAX_RESULTS = 7'd64;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic [6:0] max_len;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       accepted;
      logic [7:0] out_byte;
      logic [6:0] read_count;
      logic       last;
      logic       can_read;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

// File: hw/rtl/line_edit_input_buffer.sv
// Line-edit input buffer: write, backspace and newline editing over a ring held in one memory.
// Depends on lebuf_pkg, lebuf_mem and lebuf_ctrl.
//
// A write, a clear or a read that finds no bytes to return is answered by a single response
// in the cycle after the request, and busy stays low so a new request may follow in the next cycle.
// A read of n bytes (n = least of max_len, 64 and the committed bytes) holds busy while
// the controller steps the memory's single read port through the ring, one address a
// cycle; the bytes appear on consecutive cycles, each passing the registered read port,
// the last one carrying last and read_count. The receiver cannot stall responses.
module line_edit_input_buffer
   import lebuf_pkg::*;
#(
   parameter int BUF_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   lebuf_ctrl #(
      .BUF_DEPTH(BUF_DEPTH),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   lebuf_mem #(
      .BUF_DEPTH(BUF_DEPTH),
      .AW       (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

// File: hw/rtl/lebuf_mem.sv
// Byte store of the line-edit input buffer: one write port and one registered read port.
// Depends on nothing; depth and address width come from the parameters.
module lebuf_mem #(
   parameter int BUF_DEPTH = 64,
   parameter int AW        = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lebuf_ctrl.sv
// Controller of the line-edit input buffer: ring pointers, counts, read sequencer and result stage.
// Depends on lebuf_pkg; drives the ports of lebuf_mem.
module lebuf_ctrl
   import lebuf_pkg::*;
#(
   parameter int BUF_DEPTH = 64,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [7:0]    rd_data
);

   localparam int W  = (CW > 7) ? CW : 7;
   localparam int SW = ((AW > 7) ? AW : 7) + 1;

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] commit_ff, commit_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [6:0]    remain_ff, remain_in;
   logic [6:0]    size_ff, size_in;
   logic          byte_valid_ff, byte_valid_in;
   logic          byte_last_ff, byte_last_in;
   logic          cmd_valid_ff, cmd_valid_in;
   rsp_type       cmd_rsp_ff, cmd_rsp_in;

   logic          take;
   logic [6:0]    mlen_sat;
   logic [6:0]    size;
   logic [SW-1:0] head_sum;
   logic [AW-1:0] head_adv;
   logic [AW-1:0] tail_inc;
   logic [AW-1:0] tail_dec;
   logic [AW-1:0] rd_ptr_inc;
   logic          can_read;

   assign take     = start && !busy;
   assign mlen_sat = (req_data.max_len > MAX_RESULTS) ? MAX_RESULTS : req_data.max_len;
   assign size     = (W'(commit_ff) < W'(mlen_sat)) ? 7'(commit_ff) : mlen_sat;
   assign head_sum = SW'(head_ff) + SW'(size);
   assign head_adv = (head_sum >= SW'(BUF_DEPTH)) ? AW'(head_sum - SW'(BUF_DEPTH))
                                                  : AW'(head_sum);
   assign tail_inc   = (tail_ff == AW'(BUF_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign tail_dec   = (tail_ff == '0) ? AW'(BUF_DEPTH - 1) : tail_ff - AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == AW'(BUF_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
   assign can_read   = (commit_ff != '0);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      commit_in     = commit_ff;
      rd_ptr_in     = rd_ptr_ff;
      remain_in     = remain_ff;
      size_in       = size_ff;
      byte_valid_in = 1'b0;
      byte_last_in  = 1'b0;
      cmd_valid_in  = 1'b0;
      cmd_rsp_in    = '0;
      cmd_rsp_in.last = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = req_data.data_byte;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff;
      busy          = (state_ff == ST_READ);

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_data.operation)
                  OP_WRITE: begin
                     cmd_valid_in    = 1'b1;
                     cmd_rsp_in.kind = KIND_WRITE;
                     priority if (req_data.data_byte == CH_NUL) begin
                        cmd_rsp_in.accepted = 1'b0;
                     end else if (req_data.data_byte == CH_NEWLINE) begin
                        if (fill_ff < CW'(BUF_DEPTH - 1)) begin
                           wr_en               = 1'b1;
                           tail_in             = tail_inc;
                           fill_in             = fill_ff + CW'(1);
                           commit_in           = fill_ff + CW'(1);
                           cmd_rsp_in.accepted = 1'b1;
                        end
                     end else if (req_data.data_byte == CH_BACKSPACE) begin
                        // Only uncommitted bytes can be taken back.
                        if (fill_ff > commit_ff) begin
                           tail_in             = tail_dec;
                           fill_in             = fill_ff - CW'(1);
                           cmd_rsp_in.accepted = 1'b1;
                        end
                     end else begin
                        // Two slots are held back so a newline always fits.
                        if (fill_ff < CW'(BUF_DEPTH - 2)) begin
                           wr_en               = 1'b1;
                           tail_in             = tail_inc;
                           fill_in             = fill_ff + CW'(1);
                           cmd_rsp_in.accepted = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (size == '0) begin
                        cmd_valid_in    = 1'b1;
                        cmd_rsp_in.kind = KIND_EMPTY;
                     end else begin
                        // The counts move at once; the bytes are streamed from the old head.
                        state_in  = ST_READ;
                        rd_ptr_in = head_ff;
                        remain_in = size;
                        size_in   = size;
                        head_in   = head_adv;
                        fill_in   = fill_ff - CW'(size);
                        commit_in = commit_ff - CW'(size);
                     end
                  end
                  OP_CLEAR: begin
                     cmd_valid_in    = 1'b1;
                     cmd_rsp_in.kind = KIND_CLEAR;
                     head_in         = '0;
                     tail_in         = '0;
                     fill_in         = '0;
                     commit_in       = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en         = 1'b1;
            rd_ptr_in     = rd_ptr_inc;
            remain_in     = remain_ff - 7'd1;
            byte_valid_in = 1'b1;
            byte_last_in  = (remain_ff == 7'd1);
            if (remain_ff == 7'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         commit_ff     <= '0;
         remain_ff     <= '0;
         byte_valid_ff <= 1'b0;
         byte_last_ff  <= 1'b0;
         cmd_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         commit_ff     <= commit_in;
         remain_ff     <= remain_in;
         byte_valid_ff <= byte_valid_in;
         byte_last_ff  <= byte_last_in;
         cmd_valid_ff  <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      size_ff    <= size_in;
      cmd_rsp_ff <= cmd_rsp_in;
   end

   // The counts are already final while a response is shown, so can_read comes straight from them.
   always_comb begin
      rsp_valid = cmd_valid_ff || byte_valid_ff;
      if (byte_valid_ff) begin
         rsp_data.kind       = KIND_READ_BYTE;
         rsp_data.accepted   = 1'b0;
         rsp_data.out_byte   = rd_data;
         rsp_data.read_count = byte_last_ff ? size_ff : 7'd0;
         rsp_data.last       = byte_last_ff;
         rsp_data.can_read   = can_read;
      end else begin
         rsp_data          = cmd_rsp_ff;
         rsp_data.can_read = can_read;
      end
   end

   a_commit_within_fill: assert property (@(posedge clock) disable iff (reset)
      commit_ff <= fill_ff)
      else $error("committed end beyond fill count");

   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(BUF_DEPTH - 1))
      else $error("fill count beyond newline limit");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd_valid_ff && byte_valid_ff))
      else $error("command and read byte responses collide");

   a_read_remaining: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> remain_ff != '0)
      else $error("read sequencer running with nothing left");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      byte_valid_ff && byte_last_ff |=> !byte_valid_ff)
      else $error("read byte follows the last one");

endmodule
